FILE: rtl/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the peer presence table.
// No dependencies; used by the table top level and its checker.
package ppt_pkg;

    localparam int ADDR_W  = 48;
    localparam int ROLE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 4;
    localparam int TOTAL_W = 5;

    // one table slot as stored in the RAM
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [ROLE_W-1:0]  role;
        logic [TIME_W-1:0]  seen;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = ADDR_W + ROLE_W + TIME_W + COUNT_W;

    // commands
    localparam logic [1:0] CMD_RX    = 2'd0;
    localparam logic [1:0] CMD_SWEEP = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_ONLINE   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_OFFLINE  = 3'd4;
    localparam logic [2:0] ST_QUERY    = 3'd5;
    localparam logic [2:0] ST_REJECTED = 3'd6;
    localparam logic [2:0] ST_SWEPT    = 3'd7;

    // register map (byte addresses)
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [31:0] TIMEOUT_RST = 32'd5000;

endpackage

FILE: rtl/peer_presence_table_top.sv
`timescale 1ns / 1ps
// Peer presence table: neighbor table with aging, scanned slot by slot.
// Depends on ppt_pkg and ppt_ram.
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+----------------------------------
//  item     | in        | item_valid / item_stall   | command, address, role, ok, time
//  result   | out       | result_valid / result_stall | status, slot, peer data, totals
//  config   | in        | APB psel/penable/pready   | silence timeout at byte address 0
//
// Scan: one item per scan. The slot RAM gives one read a cycle and a single
//   compare unit (address, role or age check) looks at the slot whose read was
//   issued the cycle before; a sweep goes on scanning after each peer that
//   times out.
// Reset: rst_n is asynchronous, active low; it clears control state, the
//   connected flags, the used count and loads the silence timeout with 5000.
//   Slot RAM contents are not cleared; only slots below the used count are read.
// Stalls: the result register holds a beat while result_stall is high; the
//   scan freezes on its next result until the register frees up. A new item
//   is taken as soon as the previous one has put its last beat in the register.
module peer_presence_table_top #(
    parameter int NODE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [ppt_pkg::ADDR_W-1:0] sender_address,
    input  logic [ppt_pkg::ROLE_W-1:0] node_role,
    input  logic        frame_ok,
    input  logic [ppt_pkg::TIME_W-1:0] now_ms,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [ppt_pkg::SLOT_W-1:0]  slot_index,
    output logic [ppt_pkg::ROLE_W-1:0]  peer_role,
    output logic [ppt_pkg::ADDR_W-1:0]  peer_address,
    output logic        online,
    output logic [ppt_pkg::COUNT_W-1:0] frames_seen,
    output logic [ppt_pkg::TOTAL_W-1:0] online_total,
    output logic        last_result,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import ppt_pkg::*;

    // slot index width, and count width (holds NODE_SLOTS itself)
    localparam int AW  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CW  = $clog2(NODE_SLOTS + 1);
    localparam int SXW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int TXW = (CW > TOTAL_W) ? CW : TOTAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic [1:0]        cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ROLE_W-1:0] role_reg, role_next;
    logic              ok_reg, ok_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // scan control
    logic [CW-1:0]     iss_reg, iss_next;      // next slot to read
    logic              rdv_reg, rdv_next;      // RAM data valid this cycle
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    entry_t            hit_reg, hit_next;

    // table state
    logic [NODE_SLOTS-1:0] conn_reg, conn_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [CW-1:0]     onl_reg, onl_next;
    logic [31:0]       timeout_reg, timeout_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [ROLE_W-1:0] res_role_reg, res_role_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_online_reg, res_online_next;
    logic [COUNT_W-1:0] res_frames_reg, res_frames_next;
    logic [TOTAL_W-1:0] res_total_reg, res_total_next;
    logic              res_last_reg, res_last_next;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              out_free;
    logic              match;
    logic [TIME_W-1:0] age;
    logic              cfg_wr;
    logic [SXW-1:0]    slot_wide;
    logic [TXW-1:0]    total_wide;

    ppt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // config port: zero wait, single register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TIMEOUT);
    assign prdata = (paddr == REG_TIMEOUT) ? timeout_reg : 32'd0;

    assign item_stall = (state_reg != S_IDLE);
    assign out_free   = !res_valid_reg || !result_stall;

    // shared compare unit: one slot checked per cycle while the scan runs
    assign age = now_reg - rd_entry.seen;
    always_comb
    begin
        case (cmd_reg)
            CMD_RX:    match = (rd_entry.addr == addr_reg);
            CMD_SWEEP: match = conn_reg[cmp_idx_reg] && (age > timeout_reg);
            CMD_QUERY: match = (rd_entry.role == role_reg);
            default:   match = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        role_next       = role_reg;
        ok_next         = ok_reg;
        now_next        = now_reg;
        iss_next        = iss_reg;
        rdv_next        = rdv_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        conn_next       = conn_reg;
        used_next       = used_reg;
        onl_next        = onl_reg;
        timeout_next    = cfg_wr ? pwdata : timeout_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_role_next   = res_role_reg;
        res_addr_next   = res_addr_reg;
        res_online_next = res_online_reg;
        res_frames_next = res_frames_reg;
        res_total_next  = res_total_reg;
        res_last_next   = res_last_reg;
        res_valid_next  = res_valid_reg && result_stall;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = hit_reg;
        ram_raddr       = iss_reg[AW-1:0];
        slot_wide       = SXW'(hit_idx_reg);
        total_wide      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next  = command;
                    addr_next = sender_address;
                    role_next = node_role;
                    ok_next   = frame_ok;
                    now_next  = now_ms;
                    iss_next  = '0;
                    rdv_next  = 1'b0;
                    if ((command == CMD_RX && frame_ok) || command == CMD_SWEEP ||
                        command == CMD_QUERY)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (rdv_reg && match)
                begin
                    hit_idx_next = cmp_idx_reg;
                    hit_next     = rd_entry;
                    rdv_next     = 1'b0;
                    state_next   = S_HIT;
                end
                else if (iss_reg < used_reg)
                begin
                    iss_next     = iss_reg + CW'(1);
                    rdv_next     = 1'b1;
                    cmp_idx_next = iss_reg[AW-1:0];
                end
                else if (!rdv_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
            end

            S_HIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_slot_next  = slot_wide[SLOT_W-1:0];
                    res_role_next  = hit_reg.role;
                    res_addr_next  = hit_reg.addr;
                    case (cmd_reg)
                        CMD_RX:
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.seen  = now_reg;
                            ram_wdata.count = hit_reg.count + COUNT_W'(1);
                            conn_next[hit_idx_reg] = 1'b1;
                            if (!conn_reg[hit_idx_reg])
                            begin
                                onl_next = onl_reg + CW'(1);
                            end
                            res_status_next = conn_reg[hit_idx_reg] ? ST_UPDATED : ST_ONLINE;
                            res_online_next = 1'b1;
                            res_frames_next = hit_reg.count + COUNT_W'(1);
                            res_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        CMD_SWEEP:
                        begin
                            conn_next[hit_idx_reg] = 1'b0;
                            onl_next        = onl_reg - CW'(1);
                            res_status_next = ST_OFFLINE;
                            res_online_next = 1'b0;
                            res_frames_next = hit_reg.count;
                            res_last_next   = 1'b0;
                            iss_next        = CW'(hit_idx_reg) + CW'(1);
                            rdv_next        = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            res_status_next = ST_QUERY;
                            res_online_next = conn_reg[hit_idx_reg];
                            res_frames_next = hit_reg.count;
                            res_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    endcase
                    total_wide     = TXW'(onl_next);
                    res_total_next = total_wide[TOTAL_W-1:0];
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_last_next   = 1'b1;
                    res_slot_next   = '0;
                    res_role_next   = '0;
                    res_addr_next   = '0;
                    res_online_next = 1'b0;
                    res_frames_next = '0;
                    state_next      = S_IDLE;
                    if (cmd_reg == CMD_RX && ok_reg)
                    begin
                        res_role_next = role_reg;
                        res_addr_next = addr_reg;
                        if (used_reg >= CW'(NODE_SLOTS))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // append sender in the next free slot
                            ram_we          = 1'b1;
                            ram_waddr       = used_reg[AW-1:0];
                            ram_wdata.addr  = addr_reg;
                            ram_wdata.role  = role_reg;
                            ram_wdata.seen  = now_reg;
                            ram_wdata.count = COUNT_W'(1);
                            conn_next[used_reg[AW-1:0]] = 1'b1;
                            onl_next        = onl_reg + CW'(1);
                            used_next       = used_reg + CW'(1);
                            slot_wide       = SXW'(used_reg[AW-1:0]);
                            res_status_next = ST_ADDED;
                            res_slot_next   = slot_wide[SLOT_W-1:0];
                            res_online_next = 1'b1;
                            res_frames_next = COUNT_W'(1);
                        end
                    end
                    else if (cmd_reg == CMD_SWEEP)
                    begin
                        res_status_next = ST_SWEPT;
                    end
                    else if (cmd_reg == CMD_QUERY)
                    begin
                        res_status_next = ST_QUERY;
                        res_role_next   = role_reg;
                    end
                    else
                    begin
                        res_status_next = ST_REJECTED;
                    end
                    total_wide     = TXW'(onl_next);
                    res_total_next = total_wide[TOTAL_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            addr_reg       <= '0;
            role_reg       <= '0;
            ok_reg         <= 1'b0;
            now_reg        <= '0;
            iss_reg        <= '0;
            rdv_reg        <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_idx_reg    <= '0;
            hit_reg        <= '0;
            conn_reg       <= '0;
            used_reg       <= '0;
            onl_reg        <= '0;
            timeout_reg    <= TIMEOUT_RST;
            res_valid_reg  <= 1'b0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            res_role_reg   <= '0;
            res_addr_reg   <= '0;
            res_online_reg <= 1'b0;
            res_frames_reg <= '0;
            res_total_reg  <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            role_reg       <= role_next;
            ok_reg         <= ok_next;
            now_reg        <= now_next;
            iss_reg        <= iss_next;
            rdv_reg        <= rdv_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_idx_reg    <= hit_idx_next;
            hit_reg        <= hit_next;
            conn_reg       <= conn_next;
            used_reg       <= used_next;
            onl_reg        <= onl_next;
            timeout_reg    <= timeout_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_role_reg   <= res_role_next;
            res_addr_reg   <= res_addr_next;
            res_online_reg <= res_online_next;
            res_frames_reg <= res_frames_next;
            res_total_reg  <= res_total_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign slot_index   = res_slot_reg;
    assign peer_role    = res_role_reg;
    assign peer_address = res_addr_reg;
    assign online       = res_online_reg;
    assign frames_seen  = res_frames_reg;
    assign online_total = res_total_reg;
    assign last_result  = res_last_reg;

endmodule

FILE: rtl/ppt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ppt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the peer presence table, bound to its top level.
// Depends on ppt_pkg.
module ppt_checker #(
    parameter int NODE_SLOTS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  status,
    input logic [ppt_pkg::SLOT_W-1:0]  slot_index,
    input logic        online,
    input logic [ppt_pkg::TOTAL_W-1:0] online_total,
    input logic        last_result
);

    import ppt_pkg::*;

    // an accepted item always holds item_stall high in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken on back-to-back cycles");

    // held beat keeps its content
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) &&
        $stable(slot_index) && $stable(last_result))
        else $error("stalled result beat changed");

    // sweep closes with a bare final beat; per-peer sweep beats never close
    a_sweep_close: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_SWEPT |-> last_result && slot_index == '0 && !online)
        else $error("bad sweep closing beat");

    a_offline_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OFFLINE |-> !last_result && !online)
        else $error("bad offline beat");

    // a receive that lands in the table leaves the peer connected
    a_rx_online: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_UPDATED || status == ST_ADDED ||
        status == ST_ONLINE) |-> online && last_result &&
        online_total != '0 && (NODE_SLOTS >= 32 || online_total <= NODE_SLOTS))
        else $error("bad receive beat");

endmodule

bind peer_presence_table_top ppt_checker #(.NODE_SLOTS(NODE_SLOTS)) u_ppt_checker (.*);
